[design/nrf_pkg.sv]
// ----------------------------------------------------------------------------
// nrf_pkg
// Shared constants, codes and types of the nonce replay filter.
// ----------------------------------------------------------------------------
package nrf_pkg;

  localparam int STORE_DEPTH = 2048;
  localparam int TAG_BYTES   = 16;
  localparam int NONCE_BYTES = 24;
  localparam int WORD_W      = 64;
  localparam int NONCE_W     = 3 * WORD_W;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [15:0] MIN_FRAME_BYTES = 16'(NONCE_BYTES + TAG_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  // result status codes
  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_REPLAY   = 2'd2
  } status_t;

  // scan engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } scan_state_t;

  // request from the front end to the scan engine
  typedef struct packed {
    logic go;
    logic auth_ok;
  } scan_req_t;

  // verdict from the scan engine
  typedef struct packed {
    logic done;
    logic replay;
    logic accepted;
  } scan_rsp_t;

endpackage

[design/nrf_ram.sv]
// ----------------------------------------------------------------------------
// nrf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module nrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/nrf_scan.sv]
// ----------------------------------------------------------------------------
// nrf_scan
// Scan engine: walks the written part of the nonce ring one entry a cycle,
// compares each entry with the frame nonce, then inserts a fresh verified
// nonce at the ring pointer. Tracks pointer and full flag so that entries
// never written read as zero without a clearing pass.
// ----------------------------------------------------------------------------
module nrf_scan import nrf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  scan_req_t          req,
  input  logic [NONCE_W-1:0] nonce,
  output scan_rsp_t          rsp
);

  scan_state_t        state;
  scan_state_t        state_next;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  ptr;
  logic               full;
  logic               cmp_valid;
  logic               match;
  logic               ram_re;
  logic               ram_we;
  logic [NONCE_W-1:0] ram_rdata;
  logic               scan_last;
  logic               ring_empty;
  logic               zero_hit;
  logic               replay_now;
  logic               accept_now;

  // ring bookkeeping
  assign ring_empty = !full && (ptr == '0);
  assign scan_last  = full ? (idx == LAST_ADDR) : (idx == ptr - 1'b1);
  // unwritten entries count as zero while the ring is not yet full
  assign zero_hit   = (nonce == '0) && !full;
  assign replay_now = match || zero_hit;
  assign accept_now = !replay_now && req.auth_ok;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.go) begin
          state_next = ring_empty ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    rsp.done     = 1'b0;
    rsp.replay   = 1'b0;
    rsp.accepted = 1'b0;
    case (state)
      ST_SCAN: ram_re = 1'b1;
      ST_DECIDE: begin
        ram_we       = accept_now;
        rsp.done     = 1'b1;
        rsp.replay   = replay_now;
        rsp.accepted = accept_now;
      end
      default: ;
    endcase
  end

  // state, scan counter and compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      cmp_valid <= 1'b0;
      match     <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= ram_re;
      if (state == ST_IDLE) begin
        idx   <= '0;
        match <= 1'b0;
      end else begin
        if (ram_re) begin
          idx <= idx + 1'b1;
        end
        if (cmp_valid && (ram_rdata == nonce)) begin
          match <= 1'b1;
        end
      end
    end
  end

  // insert pointer and full flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      full <= 1'b0;
    end else if (ram_we) begin
      if (ptr == LAST_ADDR) begin
        ptr  <= '0;
        full <= 1'b1;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // seen-nonce store
  nrf_ram #(
    .WIDTH(NONCE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr),
    .wdata(nonce),
    .re   (ram_re),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // checks
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    req.go |-> state == ST_IDLE)
    else $error("scan request while engine busy");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !full) |-> idx < ptr)
    else $error("scan read beyond written entries");

  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.accepted |-> (!rsp.replay && req.auth_ok && rsp.done))
    else $error("accepted frame without clean verdict");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> state == ST_IDLE)
    else $error("engine not idle after verdict");

  a_ptr_moves: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> ptr != $past(ptr))
    else $error("insert pointer did not advance");

endmodule

[design/nonce_replay_filter.sv]
// ----------------------------------------------------------------------------
// nonce_replay_filter
// Anti-replay filter: length check, nonce ring search and insert.
// ----------------------------------------------------------------------------
// short frame: result strobe in the cycle after the start transfer, no busy time
// other frames: scan N entries, drain, decide; N = entries written (max 2048)
// rate is set by the single store read port, one ring entry per cycle
// reset clears pointer and full flag; unwritten entries read as zero, no sweep
// results are presented for one cycle only; the receiver cannot stall
module nonce_replay_filter import nrf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [15:0]       frame_length,
  input  logic [WORD_W-1:0] nonce_word_low,
  input  logic [WORD_W-1:0] nonce_word_mid,
  input  logic [WORD_W-1:0] nonce_word_high,
  input  logic              auth_ok,
  output logic              done,
  output logic [1:0]        status,
  output logic [15:0]       plaintext_length
);

  logic [15:0]        len_q;
  logic [NONCE_W-1:0] nonce_q;
  logic               auth_q;
  logic               go;
  scan_req_t          req;
  scan_rsp_t          rsp;
  status_t            status_q;

  assign req.go      = go;
  assign req.auth_ok = auth_q;
  assign status      = status_q;

  // input capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      len_q   <= frame_length;
      nonce_q <= {nonce_word_high, nonce_word_mid, nonce_word_low};
      auth_q  <= auth_ok;
    end
  end

  // transfer control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      go   <= 1'b0;
      done <= 1'b0;
    end else begin
      go   <= 1'b0;
      done <= 1'b0;
      if (start && !busy) begin
        if (frame_length < MIN_FRAME_BYTES) begin
          done             <= 1'b1;
          status_q         <= STATUS_REJECTED;
          plaintext_length <= '0;
        end else begin
          busy <= 1'b1;
          go   <= 1'b1;
        end
      end else if (rsp.done) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (rsp.replay) begin
          status_q         <= STATUS_REPLAY;
          plaintext_length <= '0;
        end else if (rsp.accepted) begin
          status_q         <= STATUS_ACCEPTED;
          plaintext_length <= len_q - MIN_FRAME_BYTES;
        end else begin
          status_q         <= STATUS_REJECTED;
          plaintext_length <= '0;
        end
      end
    end
  end

  // ring search engine
  nrf_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .nonce(nonce_q),
    .rsp  (rsp)
  );

endmodule
